// File: rtl/rlpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlpe_pkg: shared types and constants of the ranked-list evaluator
// Holds the divide job codes and the command and status groups that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package rlpe_pkg;

    localparam int TOTAL_W = 16;   // relevant_total register width
    localparam int H5_W    = 3;    // hits in top 5
    localparam int H10_W   = 4;    // hits in top 10
    localparam int H20_W   = 5;    // hits in top 20

    localparam int K_P5  = 5;
    localparam int K_P10 = 10;
    localparam int K_P20 = 20;

    // jobs of the shared divider, final ones in issue order
    typedef enum logic [2:0] {
        DIV_AP_ITEM,
        DIV_AP_FIN,
        DIV_P5,
        DIV_P10,
        DIV_P20,
        DIV_PREC,
        DIV_REC
    } t_div_sel;

    typedef struct packed {
        logic     item_step;   // count the accepted rank
        logic     div_start;   // launch a divide
        t_div_sel div_sel;     // operands of the divide and its result slot
        logic     ap_add;      // fold the per-rank quotient into the sums
        logic     res_wr;      // store a final quotient
        logic     out_load;    // load the result register and clear the list
    } t_dp_cmd;

    typedef struct packed {
        logic item_div;        // offered rank is relevant and within depth
        logic item_last;       // offered rank closes the list
        logic div_done;        // divider quotient valid this cycle
    } t_dp_status;

endpackage
`default_nettype wire

// File: rtl/rlpe_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlpe_if: channel interfaces of the ranked-list evaluator
// Rank input channel and metric result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface rlpe_in_if;
    logic valid;
    logic ready;
    logic is_relevant;
    logic last_item;

    modport source (output valid, output is_relevant, output last_item, input ready);
    modport sink   (input valid, input is_relevant, input last_item, output ready);
endinterface

interface rlpe_out_if #(
    parameter int FW = 17,
    parameter int CW = 13
);
    logic          valid;
    logic          ready;
    logic [FW-1:0] avg_precision;
    logic [FW-1:0] recip_rank;
    logic [FW-1:0] prec_at_5;
    logic [FW-1:0] prec_at_10;
    logic [FW-1:0] prec_at_20;
    logic [FW-1:0] overall_precision;
    logic [FW-1:0] overall_recall;
    logic [CW-1:0] retrieved_count;
    logic [CW-1:0] relevant_retrieved;
    logic          too_long;

    modport source (
        output valid, input ready,
        output avg_precision, output recip_rank, output prec_at_5, output prec_at_10,
        output prec_at_20, output overall_precision, output overall_recall,
        output retrieved_count, output relevant_retrieved, output too_long
    );
    modport sink (
        input valid, output ready,
        input avg_precision, input recip_rank, input prec_at_5, input prec_at_10,
        input prec_at_20, input overall_precision, input overall_recall,
        input retrieved_count, input relevant_retrieved, input too_long
    );
endinterface
`default_nettype wire

// File: rtl/rlpe_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlpe_divider: radix-2 restoring divider with fraction saturation
// One quotient bit per cycle; quotients above one saturate to one,
// a zero divisor gives zero.
// ---------------------------------------------------------------------------
module rlpe_divider #(
    parameter int AW        = 29,
    parameter int DW        = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [AW-1:0]        i_num,
    input  wire logic [DW-1:0]        i_den,
    output logic      [FRAC_BITS:0]   o_quot,
    output logic                      o_done
);

    localparam int QW = FRAC_BITS + 2;     // quotient bits developed
    localparam int NW = $clog2(QW + 1);
    localparam logic [QW-1:0] Q_ONE = QW'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] F_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic              r_busy;
    logic [NW-1:0]     r_cnt;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [QW-1:0]     r_lo;
    logic [QW-1:0]     r_q;
    logic              r_done;
    logic [FRAC_BITS:0] r_quot;

    logic [DW-1:0] w_hi;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [QW-1:0] w_q_next;

    always_comb begin
        w_hi     = DW'(i_num[AW-1:QW]);
        w_trial  = {r_rem, r_lo[QW-1]};
        w_diff   = w_trial - {1'b0, r_den};
        w_ge     = (w_trial >= {1'b0, r_den});
        w_q_next = {r_q[QW-2:0], w_ge};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0 || w_hi >= i_den) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= NW'(QW);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_hi;
            r_den <= i_den;
            r_lo  <= i_num[QW-1:0];
            r_q   <= '0;
            if (i_den == '0) begin
                r_quot <= '0;
            end else if (w_hi >= i_den) begin
                r_quot <= F_ONE;
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_lo  <= {r_lo[QW-2:0], 1'b0};
            r_q   <= w_q_next;
            if (r_cnt == NW'(1)) begin
                r_quot <= (w_q_next > Q_ONE) ? F_ONE : w_q_next[FRAC_BITS:0];
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule
`default_nettype wire

// File: rtl/rlpe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlpe_datapath: list counters, running sums and result registers
// Keeps rank and hit counts, the precision sum and reciprocal rank, feeds
// the shared divider and holds the outgoing metrics.
// ---------------------------------------------------------------------------
module rlpe_datapath #(
    parameter int MAX_DEPTH = 4096,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire rlpe_pkg::t_dp_cmd                   i_cmd,
    output rlpe_pkg::t_dp_status                     o_status,
    input  wire logic                                i_cfg_we,
    input  wire logic [rlpe_pkg::TOTAL_W-1:0]        i_cfg_data,
    input  wire logic                                i_is_relevant,
    input  wire logic                                i_last_item,
    output logic [FRAC_BITS:0]                       o_avg_precision,
    output logic [FRAC_BITS:0]                       o_recip_rank,
    output logic [FRAC_BITS:0]                       o_prec_at_5,
    output logic [FRAC_BITS:0]                       o_prec_at_10,
    output logic [FRAC_BITS:0]                       o_prec_at_20,
    output logic [FRAC_BITS:0]                       o_overall_precision,
    output logic [FRAC_BITS:0]                       o_overall_recall,
    output logic [$clog2(MAX_DEPTH+1)-1:0]           o_retrieved_count,
    output logic [$clog2(MAX_DEPTH+1)-1:0]           o_relevant_retrieved,
    output logic                                     o_too_long
);

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int FW = FRAC_BITS + 1;
    localparam int AW = CW + FRAC_BITS;
    localparam int DW = (CW > rlpe_pkg::TOTAL_W) ? CW : rlpe_pkg::TOTAL_W;

    // configuration and list state
    logic [rlpe_pkg::TOTAL_W-1:0] r_total;
    logic [CW-1:0]                r_rank;
    logic [CW-1:0]                r_seen;
    logic [AW-1:0]                r_ap_sum;
    logic [FW-1:0]                r_rr;
    logic [rlpe_pkg::H5_W-1:0]    r_h5;
    logic [rlpe_pkg::H10_W-1:0]   r_h10;
    logic [rlpe_pkg::H20_W-1:0]   r_h20;
    logic                         r_ovf;

    // final quotients
    logic [FW-1:0] r_q_ap;
    logic [FW-1:0] r_q_p5;
    logic [FW-1:0] r_q_p10;
    logic [FW-1:0] r_q_p20;
    logic [FW-1:0] r_q_prec;
    logic [FW-1:0] r_q_rec;

    // result register
    logic [FW-1:0] r_o_ap;
    logic [FW-1:0] r_o_rr;
    logic [FW-1:0] r_o_p5;
    logic [FW-1:0] r_o_p10;
    logic [FW-1:0] r_o_p20;
    logic [FW-1:0] r_o_prec;
    logic [FW-1:0] r_o_rec;
    logic [CW-1:0] r_o_ret;
    logic [CW-1:0] r_o_rel;
    logic          r_o_long;

    logic          w_full;
    logic          w_none;
    logic [AW-1:0] w_num;
    logic [DW-1:0] w_den;
    logic [FW-1:0] w_quot;
    logic          w_done;

    assign w_full = (r_rank == CW'(MAX_DEPTH));
    assign w_none = (r_total == '0);

    assign o_status.item_div  = i_is_relevant && !w_full;
    assign o_status.item_last = i_last_item;
    assign o_status.div_done  = w_done;

    // divider operands
    always_comb begin
        unique case (i_cmd.div_sel)
            rlpe_pkg::DIV_AP_ITEM: begin
                w_num = {r_seen, {FRAC_BITS{1'b0}}};
                w_den = DW'(r_rank);
            end
            rlpe_pkg::DIV_AP_FIN: begin
                w_num = r_ap_sum;
                w_den = DW'(r_total);
            end
            rlpe_pkg::DIV_P5: begin
                w_num = AW'({r_h5, {FRAC_BITS{1'b0}}});
                w_den = DW'(rlpe_pkg::K_P5);
            end
            rlpe_pkg::DIV_P10: begin
                w_num = AW'({r_h10, {FRAC_BITS{1'b0}}});
                w_den = DW'(rlpe_pkg::K_P10);
            end
            rlpe_pkg::DIV_P20: begin
                w_num = AW'({r_h20, {FRAC_BITS{1'b0}}});
                w_den = DW'(rlpe_pkg::K_P20);
            end
            rlpe_pkg::DIV_PREC: begin
                w_num = {r_seen, {FRAC_BITS{1'b0}}};
                w_den = DW'(r_rank);
            end
            rlpe_pkg::DIV_REC: begin
                w_num = {r_seen, {FRAC_BITS{1'b0}}};
                w_den = DW'(r_total);
            end
            default: begin
                w_num = '0;
                w_den = '0;
            end
        endcase
    end

    rlpe_divider #(
        .AW        (AW),
        .DW        (DW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quot  (w_quot),
        .o_done  (w_done)
    );

    // list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_rank   <= '0;
            r_seen   <= '0;
            r_ap_sum <= '0;
            r_rr     <= '0;
            r_h5     <= '0;
            r_h10    <= '0;
            r_h20    <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_rank   <= '0;
                r_seen   <= '0;
                r_ap_sum <= '0;
                r_rr     <= '0;
                r_h5     <= '0;
                r_h10    <= '0;
                r_h20    <= '0;
                r_ovf    <= 1'b0;
            end else begin
                if (i_cmd.item_step) begin
                    if (w_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_rank <= r_rank + CW'(1);
                        if (i_is_relevant) begin
                            r_seen <= r_seen + CW'(1);
                            if (r_rank < CW'(rlpe_pkg::K_P5)) begin
                                r_h5 <= r_h5 + rlpe_pkg::H5_W'(1);
                            end
                            if (r_rank < CW'(rlpe_pkg::K_P10)) begin
                                r_h10 <= r_h10 + rlpe_pkg::H10_W'(1);
                            end
                            if (r_rank < CW'(rlpe_pkg::K_P20)) begin
                                r_h20 <= r_h20 + rlpe_pkg::H20_W'(1);
                            end
                        end
                    end
                end
                if (i_cmd.ap_add) begin
                    r_ap_sum <= r_ap_sum + AW'(w_quot);
                    // reciprocal rank comes from the first relevant rank only
                    if (r_seen == CW'(1)) begin
                        r_rr <= w_quot;
                    end
                end
            end
        end
    end

    // quotient slots and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_wr) begin
            unique case (i_cmd.div_sel)
                rlpe_pkg::DIV_AP_FIN: r_q_ap   <= w_quot;
                rlpe_pkg::DIV_P5:     r_q_p5   <= w_quot;
                rlpe_pkg::DIV_P10:    r_q_p10  <= w_quot;
                rlpe_pkg::DIV_P20:    r_q_p20  <= w_quot;
                rlpe_pkg::DIV_PREC:   r_q_prec <= w_quot;
                rlpe_pkg::DIV_REC:    r_q_rec  <= w_quot;
                default: ;
            endcase
        end
        if (i_cmd.out_load) begin
            r_o_ap   <= w_none ? '0 : r_q_ap;
            r_o_rr   <= w_none ? '0 : r_rr;
            r_o_p5   <= w_none ? '0 : r_q_p5;
            r_o_p10  <= w_none ? '0 : r_q_p10;
            r_o_p20  <= w_none ? '0 : r_q_p20;
            r_o_prec <= w_none ? '0 : r_q_prec;
            r_o_rec  <= w_none ? '0 : r_q_rec;
            r_o_ret  <= r_rank;
            r_o_rel  <= w_none ? '0 : r_seen;
            r_o_long <= r_ovf;
        end
    end

    assign o_avg_precision      = r_o_ap;
    assign o_recip_rank         = r_o_rr;
    assign o_prec_at_5          = r_o_p5;
    assign o_prec_at_10         = r_o_p10;
    assign o_prec_at_20         = r_o_p20;
    assign o_overall_precision  = r_o_prec;
    assign o_overall_recall     = r_o_rec;
    assign o_retrieved_count    = r_o_ret;
    assign o_relevant_retrieved = r_o_rel;
    assign o_too_long           = r_o_long;

endmodule
`default_nettype wire

// File: rtl/rlpe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlpe_ctrl: sequencer of the ranked-list evaluator
// Accepts ranks, runs the per-rank and end-of-list divides and hands the
// metrics to the result register.
// ---------------------------------------------------------------------------
module rlpe_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    input  wire rlpe_pkg::t_dp_status  i_status,
    output rlpe_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_LOAD
    } t_state;

    t_state             r_state;
    rlpe_pkg::t_div_sel r_job;
    logic               r_last;
    logic               r_out_valid;

    logic w_accept;
    logic w_load;

    function automatic rlpe_pkg::t_div_sel next_job(input rlpe_pkg::t_div_sel job);
        rlpe_pkg::t_div_sel nxt;
        unique case (job)
            rlpe_pkg::DIV_AP_FIN: nxt = rlpe_pkg::DIV_P5;
            rlpe_pkg::DIV_P5:     nxt = rlpe_pkg::DIV_P10;
            rlpe_pkg::DIV_P10:    nxt = rlpe_pkg::DIV_P20;
            rlpe_pkg::DIV_P20:    nxt = rlpe_pkg::DIV_PREC;
            rlpe_pkg::DIV_PREC:   nxt = rlpe_pkg::DIV_REC;
            default:              nxt = rlpe_pkg::DIV_AP_FIN;
        endcase
        return nxt;
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;
    assign w_load     = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd.item_step = w_accept;
        o_cmd.div_start = (r_state == S_DIV_GO);
        o_cmd.div_sel   = r_job;
        o_cmd.ap_add    = (r_state == S_DIV_WAIT) && i_status.div_done
                          && (r_job == rlpe_pkg::DIV_AP_ITEM);
        o_cmd.res_wr    = (r_state == S_DIV_WAIT) && i_status.div_done
                          && (r_job != rlpe_pkg::DIV_AP_ITEM);
        o_cmd.out_load  = w_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= rlpe_pkg::DIV_AP_ITEM;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last <= i_status.item_last;
                        if (i_status.item_div) begin
                            r_job   <= rlpe_pkg::DIV_AP_ITEM;
                            r_state <= S_DIV_GO;
                        end else if (i_status.item_last) begin
                            r_job   <= rlpe_pkg::DIV_AP_FIN;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (i_status.div_done) begin
                        priority if (r_job == rlpe_pkg::DIV_AP_ITEM) begin
                            if (r_last) begin
                                r_job   <= rlpe_pkg::DIV_AP_FIN;
                                r_state <= S_DIV_GO;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else if (r_job == rlpe_pkg::DIV_REC) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_job   <= next_job(r_job);
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_LOAD: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: rtl/ranked_list_precision_ap_eval_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ranked_list_precision_ap_eval_top: ranked-list precision evaluator
// Takes a ranked list one rank per transaction and, on the closing rank,
// returns average precision, reciprocal rank, P@5/10/20, precision, recall
// and the counts, all fractions unsigned Q1.FRAC_BITS with floor rounding.
//
//   channel   dir  handshake     payload
//   i_in      in   valid/ready   is_relevant, last_item
//   o_res     out  valid/ready   ten metric fields, one transaction per list
//   i_cfg_*   in   write enable  relevant_total (16 bit)
//
// a rank that is not relevant, or lies past MAX_DEPTH, runs no per-rank divide
// a relevant rank runs one divide of seen*ONE by rank on the radix-2 divider;
//   no new rank is accepted until that divide is done
// the closing rank adds six divides and a load of the result register;
//   a new list may start while that result waits
// i_rst_n is synchronous, active low; it clears the sequencer, list state
//   and relevant_total; no clearing pass is needed
// o_res stalls only block the load of the next list's result
// ---------------------------------------------------------------------------
module ranked_list_precision_ap_eval_top #(
    parameter int MAX_DEPTH = 4096,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rlpe_in_if.sink                            i_in,
    rlpe_out_if.source                         o_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [rlpe_pkg::TOTAL_W-1:0]  i_cfg_data
);

    // command and status between sequencer and datapath
    rlpe_pkg::t_dp_cmd    w_cmd;
    rlpe_pkg::t_dp_status w_status;

    logic w_in_ready;
    logic w_out_valid;

    // sequencer: rank acceptance, divide jobs, result handoff
    rlpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // counters, sums, shared divider and result register
    rlpe_datapath #(
        .MAX_DEPTH (MAX_DEPTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_data           (i_cfg_data),
        .i_is_relevant        (i_in.is_relevant),
        .i_last_item          (i_in.last_item),
        .o_avg_precision      (o_res.avg_precision),
        .o_recip_rank         (o_res.recip_rank),
        .o_prec_at_5          (o_res.prec_at_5),
        .o_prec_at_10         (o_res.prec_at_10),
        .o_prec_at_20         (o_res.prec_at_20),
        .o_overall_precision  (o_res.overall_precision),
        .o_overall_recall     (o_res.overall_recall),
        .o_retrieved_count    (o_res.retrieved_count),
        .o_relevant_retrieved (o_res.relevant_retrieved),
        .o_too_long           (o_res.too_long)
    );

    assign i_in.ready  = w_in_ready;
    assign o_res.valid = w_out_valid;

endmodule
`default_nettype wire

// File: rtl/rlpe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rlpe_checker: port-level checks of the ranked-list evaluator
// Watches the rank and result channels and the consistency of results.
// ---------------------------------------------------------------------------
module rlpe_checker #(
    parameter int MAX_DEPTH = 4096,
    parameter int FRAC_BITS = 16
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               i_in_ready,
    input wire logic                               i_in_last,
    input wire logic                               i_out_valid,
    input wire logic                               i_out_ready,
    input wire logic [FRAC_BITS:0]                 i_avg_precision,
    input wire logic [FRAC_BITS:0]                 i_overall_recall,
    input wire logic [$clog2(MAX_DEPTH+1)-1:0]     i_retrieved_count,
    input wire logic [$clog2(MAX_DEPTH+1)-1:0]     i_relevant_retrieved,
    input wire logic                               i_too_long
);

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam logic [FRAC_BITS:0] F_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_avg_precision)
            && $stable(i_retrieved_count) && $stable(i_too_long))
        else $error("result changed while stalled");

    // the closing rank always starts end-of-list work
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("rank accepted right after a closing rank");

    a_rel_le_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_relevant_retrieved <= i_retrieved_count)
        else $error("more relevant ranks than ranks");

    a_frac_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_avg_precision <= F_ONE && i_overall_recall <= F_ONE)
        else $error("fraction above one");

    a_too_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_too_long |-> i_retrieved_count == CW'(MAX_DEPTH))
        else $error("overlong list not counted to full depth");

endmodule

bind ranked_list_precision_ap_eval_top rlpe_checker #(
    .MAX_DEPTH (MAX_DEPTH),
    .FRAC_BITS (FRAC_BITS)
) u_rlpe_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in.valid),
    .i_in_ready           (i_in.ready),
    .i_in_last            (i_in.last_item),
    .i_out_valid          (o_res.valid),
    .i_out_ready          (o_res.ready),
    .i_avg_precision      (o_res.avg_precision),
    .i_overall_recall     (o_res.overall_recall),
    .i_retrieved_count    (o_res.retrieved_count),
    .i_relevant_retrieved (o_res.relevant_retrieved),
    .i_too_long           (o_res.too_long)
);
`default_nettype wire
